>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the id/colour hash table.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_HOLDS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/icht_pkg.sv
// Shared types, constants and helper functions of the id/colour hash table.
// No dependencies.
package icht_pkg;

    localparam int TABLE_AW    = 12;
    localparam int TABLE_DEPTH = 1 << TABLE_AW;
    localparam int COUNT_W     = TABLE_AW + 1;
    localparam int KEY_W       = 24;
    localparam int ID_W        = 32;

    localparam logic [31:0] HASH_MULT = 32'h045d_9f3b;

    typedef enum logic [1:0] {
        REQ_ASSIGN = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_CLEAR  = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MIX1,
        ST_MIX2,
        ST_PROBE_RD,
        ST_PROBE_CHK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              used;
        logic [KEY_W-1:0]  key;
        logic [ID_W-1:0]   ent;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    // Key layout: red in the top byte, blue in the bottom byte.
    function automatic logic [KEY_W-1:0] key_of_hash(input logic [31:0] h);
        key_of_hash = {h[7:0], h[15:8], h[23:16]};
    endfunction

    // Home slot is the key modulo the (power of two) depth.
    function automatic logic [TABLE_AW-1:0] home_of(input logic [KEY_W-1:0] key);
        home_of = key[TABLE_AW-1:0];
    endfunction

endpackage

>>> rtl/icht_mix_unit.sv
// One round of the multiply-xorshift mix: ((x >> 16) ^ x) * HASH_MULT, registered.
// Shared by both hash rounds. Depends on icht_pkg.
module icht_mix_unit (
    input  logic        i_clk,
    input  logic [31:0] i_x,
    output logic [31:0] o_p
);

    logic [31:0] folded;
    logic [31:0] n_p;
    logic [31:0] r_p;

    assign folded = i_x ^ (i_x >> 16);
    assign n_p    = 32'(folded * icht_pkg::HASH_MULT);

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
    end

    assign o_p = r_p;

endmodule

>>> rtl/icht_slot_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds the slot table. No dependencies.
module icht_slot_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] mem [1 << ADDR_W];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/id_color_hash_table.sv
// Top level of the id/colour hash table: request sequencer, probe logic and result registers.
// Depends on icht_pkg, icht_mix_unit, icht_slot_ram and assert_macros.svh.
//
// Usage:
//   A request transfers at a rising edge with start high and busy low. The
//   fields are i_req_type (0 assign, 1 lookup, 2 clear), i_entity_id and the
//   colour bytes. Exactly one result follows: o_valid is high for one cycle
//   with o_out_red/green/blue (assign only) and o_found_id (lookup only);
//   unused fields are zero. The receiver cannot stall; the result is gone
//   after that cycle. busy stays high from the transfer until the result.
// Steps per request type:
//   assign: two passes through the shared multiplier, then probes
//   lookup: probes only
//   clear:  one slot written per cycle over all TABLE_DEPTH slots (4096 here)
//   request type 3: no change to the table.
// Probing runs at one slot per cycle, set by the registered RAM read port.
// Reset: synchronous, active low; afterwards the block runs a clearing pass
// over all TABLE_DEPTH slots with busy high, and gives no result.
module id_color_hash_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_req_type,
    input  logic signed [31:0] i_entity_id,
    input  logic [7:0]         i_color_red,
    input  logic [7:0]         i_color_green,
    input  logic [7:0]         i_color_blue,
    output logic               o_valid,
    output logic [7:0]         o_out_red,
    output logic [7:0]         o_out_green,
    output logic [7:0]         o_out_blue,
    output logic signed [31:0] o_found_id
);

    localparam int AW = icht_pkg::TABLE_AW;
    localparam int CW = icht_pkg::COUNT_W;

    icht_pkg::t_state r_state, n_state;
    icht_pkg::t_req   r_kind;
    logic                        r_clr_reply;
    logic [AW-1:0]               r_slot;
    logic [AW-1:0]               r_home;
    logic [CW-1:0]               r_count;
    logic [icht_pkg::KEY_W-1:0]  r_key;
    logic [icht_pkg::ID_W-1:0]   r_id;
    logic [7:0]                  r_red, r_green, r_blue;
    logic [icht_pkg::ID_W-1:0]   r_found;

    logic                        accept;
    logic [31:0]                 mix_in, mix_p, hash;
    logic [icht_pkg::KEY_W-1:0]  cur_key;
    icht_pkg::t_slot             rd_slot, wr_slot;
    logic [icht_pkg::SLOT_W-1:0] rd_bits;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr, rd_addr;
    logic                        chk_hit, chk_free, chk_last, chk_done;

    assign accept = start && (r_state == icht_pkg::ST_IDLE);

    // Shared multiplier: first round takes the id, second its own product.
    assign mix_in = (r_state == icht_pkg::ST_MIX1) ? r_id : mix_p;

    icht_mix_unit u_mix (
        .i_clk (i_clk),
        .i_x   (mix_in),
        .o_p   (mix_p)
    );

    assign hash    = mix_p ^ (mix_p >> 16);
    assign cur_key = (r_kind == icht_pkg::REQ_ASSIGN) ? icht_pkg::key_of_hash(hash) : r_key;

    icht_slot_ram #(
        .DATA_W (icht_pkg::SLOT_W),
        .ADDR_W (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_slot),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_bits)
    );

    assign rd_slot  = icht_pkg::t_slot'(rd_bits);
    assign chk_free = !rd_slot.used;
    assign chk_hit  = rd_slot.used && (rd_slot.key == r_key);
    assign chk_last = (r_count == CW'(icht_pkg::TABLE_DEPTH - 1));
    assign chk_done = chk_free || chk_hit || chk_last;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            icht_pkg::ST_CLEAR: begin
                if (r_slot == '1) begin
                    n_state = r_clr_reply ? icht_pkg::ST_DONE : icht_pkg::ST_IDLE;
                end
            end
            icht_pkg::ST_IDLE: begin
                if (start) begin
                    unique case (i_req_type)
                        icht_pkg::REQ_ASSIGN: n_state = icht_pkg::ST_MIX1;
                        icht_pkg::REQ_LOOKUP: n_state = icht_pkg::ST_PROBE_RD;
                        icht_pkg::REQ_CLEAR:  n_state = icht_pkg::ST_CLEAR;
                        default:              n_state = icht_pkg::ST_DONE;
                    endcase
                end
            end
            icht_pkg::ST_MIX1:     n_state = icht_pkg::ST_MIX2;
            icht_pkg::ST_MIX2:     n_state = icht_pkg::ST_PROBE_RD;
            icht_pkg::ST_PROBE_RD: n_state = icht_pkg::ST_PROBE_CHK;
            icht_pkg::ST_PROBE_CHK: begin
                if (chk_done) begin
                    n_state = icht_pkg::ST_DONE;
                end
            end
            icht_pkg::ST_DONE:     n_state = icht_pkg::ST_IDLE;
            default:               n_state = icht_pkg::ST_IDLE;
        endcase
    end

    // RAM control
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_slot;
        wr_slot = '{used: 1'b1, key: r_key, ent: r_id};
        rd_addr = r_slot + AW'(1);
        unique case (r_state)
            icht_pkg::ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_slot = '0;
            end
            icht_pkg::ST_PROBE_RD: begin
                rd_addr = icht_pkg::home_of(cur_key);
            end
            icht_pkg::ST_PROBE_CHK: begin
                if (r_kind == icht_pkg::REQ_ASSIGN) begin
                    // Write a free or matching slot; table full: fall back to the home slot.
                    priority if (chk_free || chk_hit) begin
                        wr_en = 1'b1;
                    end else if (chk_last) begin
                        wr_en   = 1'b1;
                        wr_addr = r_home;
                    end else begin
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= icht_pkg::ST_CLEAR;
            r_slot      <= '0;
            r_count     <= '0;
            r_clr_reply <= 1'b0;
            r_kind      <= icht_pkg::REQ_CLEAR;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                icht_pkg::ST_CLEAR: begin
                    r_slot <= r_slot + AW'(1);
                end
                icht_pkg::ST_IDLE: begin
                    if (accept) begin
                        r_kind      <= icht_pkg::t_req'(i_req_type);
                        r_clr_reply <= 1'b1;
                        r_slot      <= '0;
                    end
                end
                icht_pkg::ST_PROBE_RD: begin
                    r_slot  <= icht_pkg::home_of(cur_key);
                    r_count <= '0;
                end
                icht_pkg::ST_PROBE_CHK: begin
                    if (!chk_done) begin
                        r_slot  <= r_slot + AW'(1);
                        r_count <= r_count + CW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Payload and result registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_id    <= i_entity_id;
            r_key   <= {i_color_red, i_color_green, i_color_blue};
            r_red   <= '0;
            r_green <= '0;
            r_blue  <= '0;
            r_found <= '0;
        end
        if (r_state == icht_pkg::ST_PROBE_RD) begin
            r_key  <= cur_key;
            r_home <= icht_pkg::home_of(cur_key);
            if (r_kind == icht_pkg::REQ_ASSIGN) begin
                r_red   <= hash[7:0];
                r_green <= hash[15:8];
                r_blue  <= hash[23:16];
            end
        end
        if (r_state == icht_pkg::ST_PROBE_CHK && r_kind == icht_pkg::REQ_LOOKUP && chk_hit) begin
            r_found <= rd_slot.ent;
        end
    end

    assign busy        = (r_state != icht_pkg::ST_IDLE);
    assign o_valid     = (r_state == icht_pkg::ST_DONE);
    assign o_out_red   = r_red;
    assign o_out_green = r_green;
    assign o_out_blue  = r_blue;
    assign o_found_id  = r_found;

`include "assert_macros.svh"

    `ASSERT_NEXT(a_valid_one_cycle, i_clk, i_rst_n, o_valid, !o_valid)
    `ASSERT_IMPLIES(a_wr_only_clear_or_chk, i_clk, i_rst_n, wr_en, (r_state == icht_pkg::ST_CLEAR) || (r_state == icht_pkg::ST_PROBE_CHK))
    `ASSERT_IMPLIES(a_found_excl_colour, i_clk, i_rst_n, o_valid && (o_found_id != 0), (o_out_red == 0) && (o_out_green == 0) && (o_out_blue == 0))
    `ASSERT_HOLDS(a_count_in_range, i_clk, i_rst_n, r_count < CW'(icht_pkg::TABLE_DEPTH))
    `ASSERT_IMPLIES(a_lookup_no_write, i_clk, i_rst_n, (r_state == icht_pkg::ST_PROBE_CHK) && (r_kind != icht_pkg::REQ_ASSIGN), !wr_en)

endmodule
